/* sv/ggvc_pkg.sv */
package ggvc_pkg;

  localparam int VW  = 60;
  localparam int RW  = 52;
  localparam int ZW  = 33;
  localparam int EXW = RW - 16;

  localparam logic signed [63:0] GAIN_Q30        = 64'sd652032874;
  localparam logic signed [18:0] FWD_GAIN_Q16    = 19'sd72090;
  localparam logic        [33:0] FWD_DROP_Q16    = 34'd64881;
  localparam logic signed [50:0] STRAFE_GAIN_Q16 = 51'sd6554;
  localparam logic signed [36:0] PATH_TURN_Q16   = 37'sd452952;
  localparam logic signed [36:0] HEAD_TURN_Q16   = 37'sd247065;
  localparam logic signed [EXW-1:0] SWITCH_Q16   = EXW'(19661);

  typedef enum logic [2:0] {
    REG_GOAL_X  = 3'd0,
    REG_GOAL_Y  = 3'd1,
    REG_GOAL_QW = 3'd2,
    REG_GOAL_QX = 3'd3,
    REG_GOAL_QY = 3'd4,
    REG_GOAL_QZ = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] forward_speed;
    logic signed [31:0] strafe_speed;
    logic signed [31:0] turn_rate;
  } out_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic        [31:0]   acc;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    vec_t                 yaw;
    vec_t                 gyaw;
    vec_t                 brg;
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] ry;
  } vstage_t;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0]   ep;
    logic signed [15:0]   eh;
  } rstage_t;

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10680862;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [31:0] r;
    t = (v + 64'sd32768) >>> 16;
    if (t > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (t < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/ggvc_in_if.sv */
interface ggvc_in_if;
  logic             valid;
  logic             ready;
  ggvc_pkg::in_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/ggvc_out_if.sv */
interface ggvc_out_if;
  logic             valid;
  logic             ready;
  ggvc_pkg::out_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/ggvc_vec_cell.sv */
module ggvc_vec_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              en,
  input  ggvc_pkg::vstage_t d_i,
  output ggvc_pkg::vstage_t d_o
);

  ggvc_pkg::vstage_t d_r, d_nxt;

  function automatic ggvc_pkg::vec_t vec_step(input ggvc_pkg::vec_t v);
    logic signed [ggvc_pkg::VW-1:0] xs;
    logic signed [ggvc_pkg::VW-1:0] ys;
    ggvc_pkg::vec_t r;
    xs = v.x >>> IDX;
    ys = v.y >>> IDX;
    r = v;
    if (v.y > 0) begin
      r.x   = v.x + ys;
      r.y   = v.y - xs;
      r.acc = v.acc + ggvc_pkg::atan_val(5'(IDX));
    end else begin
      r.x   = v.x - ys;
      r.y   = v.y + xs;
      r.acc = v.acc - ggvc_pkg::atan_val(5'(IDX));
    end
    return r;
  endfunction

  always_comb begin
    d_nxt      = d_i;
    d_nxt.yaw  = vec_step(d_i.yaw);
    d_nxt.gyaw = vec_step(d_i.gyaw);
    d_nxt.brg  = vec_step(d_i.brg);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

/* sv/ggvc_rot_cell.sv */
module ggvc_rot_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              en,
  input  ggvc_pkg::rstage_t d_i,
  output ggvc_pkg::rstage_t d_o
);

  ggvc_pkg::rstage_t d_r, d_nxt;
  logic signed [ggvc_pkg::RW-1:0] xs, ys;
  logic signed [ggvc_pkg::ZW-1:0] at;

  always_comb begin
    xs    = d_i.x >>> IDX;
    ys    = d_i.y >>> IDX;
    at    = $signed({1'b0, ggvc_pkg::atan_val(5'(IDX))});
    d_nxt = d_i;
    if (d_i.z >= 0) begin
      d_nxt.x = d_i.x - ys;
      d_nxt.y = d_i.y + xs;
      d_nxt.z = d_i.z - at;
    end else begin
      d_nxt.x = d_i.x + ys;
      d_nxt.y = d_i.y - xs;
      d_nxt.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

/* sv/go_to_goal_velocity_controller.sv */
// Go-to-goal velocity controller. Each pose transaction on in_ch yields one velocity
// command on out_ch. The command is presented once the pose has passed through the whole
// pipeline, and is held on out_ch until the output side takes it. One pose is accepted
// every cycle while the output side does not stall: the yaw, goal yaw and
// bearing CORDIC vectoring chains run side by side, one stage per cell, followed by a
// CORDIC rotation chain of the same length and a short multiply and saturate tail.
// Write the goal registers over the cfg port only while no transaction is in flight.
module go_to_goal_velocity_controller #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata,
  ggvc_in_if.sink           in_ch,
  ggvc_out_if.source        out_ch
);

  localparam int S   = CORDIC_STAGES;
  localparam int L   = 2 * S + 8;
  localparam int VW  = ggvc_pkg::VW;
  localparam int RW  = ggvc_pkg::RW;
  localparam int EXW = ggvc_pkg::EXW;

  logic signed [31:0] goal_x_r, goal_y_r;
  logic signed [15:0] goal_qw_r, goal_qx_r, goal_qy_r, goal_qz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r  <= '0;
      goal_y_r  <= '0;
      goal_qw_r <= 16'sd16384;
      goal_qx_r <= '0;
      goal_qy_r <= '0;
      goal_qz_r <= '0;
    end else if (cfg_we) begin
      unique case (ggvc_pkg::cfg_reg_t'(cfg_idx))
        ggvc_pkg::REG_GOAL_X:  goal_x_r  <= cfg_wdata;
        ggvc_pkg::REG_GOAL_Y:  goal_y_r  <= cfg_wdata;
        ggvc_pkg::REG_GOAL_QW: goal_qw_r <= cfg_wdata[15:0];
        ggvc_pkg::REG_GOAL_QX: goal_qx_r <= cfg_wdata[15:0];
        ggvc_pkg::REG_GOAL_QY: goal_qy_r <= cfg_wdata[15:0];
        ggvc_pkg::REG_GOAL_QZ: goal_qz_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [L-1:0] v_r;
  logic [L:0]   en;

  always_comb begin
    en[L] = out_ch.ready;
    for (int k = L - 1; k >= 0; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < L; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready = en[0];

  logic signed [31:0] wz_r, xy_r, yy_r, zz_r;
  logic signed [31:0] gwz_r, gxy_r, gyy_r, gzz_r;
  logic signed [32:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      wz_r  <= in_ch.data.quat_w * in_ch.data.quat_z;
      xy_r  <= in_ch.data.quat_x * in_ch.data.quat_y;
      yy_r  <= in_ch.data.quat_y * in_ch.data.quat_y;
      zz_r  <= in_ch.data.quat_z * in_ch.data.quat_z;
      gwz_r <= goal_qw_r * goal_qz_r;
      gxy_r <= goal_qx_r * goal_qy_r;
      gyy_r <= goal_qy_r * goal_qy_r;
      gzz_r <= goal_qz_r * goal_qz_r;
      dx_r  <= 33'(goal_x_r) - 33'(in_ch.data.pos_x);
      dy_r  <= 33'(goal_y_r) - 33'(in_ch.data.pos_y);
    end
  end

  function automatic ggvc_pkg::vec_t vec_prep(input logic signed [34:0] xin,
                                              input logic signed [34:0] yin);
    ggvc_pkg::vec_t r;
    r.zero = (xin == 0) && (yin == 0);
    r.x    = VW'(xin) <<< 20;
    r.y    = VW'(yin) <<< 20;
    r.acc  = 32'h0;
    if (xin < 0) begin
      r.x   = -r.x;
      r.y   = -r.y;
      r.acc = 32'h8000_0000;
    end
    return r;
  endfunction

  function automatic logic signed [RW-1:0] rot_scale(input logic signed [32:0] d);
    logic signed [63:0] p;
    p = 64'(d) * ggvc_pkg::GAIN_Q30;
    p = (p + 64'sd8192) >>> 14;
    return p[RW-1:0];
  endfunction

  function automatic logic [15:0] ang16(input ggvc_pkg::vec_t v);
    logic [31:0] t;
    t = v.acc + 32'h0000_8000;
    return v.zero ? 16'h0 : t[31:16];
  endfunction

  logic signed [34:0] num, den, gnum, gden;
  ggvc_pkg::vstage_t  vs0_r;

  always_comb begin
    num  = (35'(wz_r) + 35'(xy_r)) <<< 1;
    den  = 35'sd268435456 - ((35'(yy_r) + 35'(zz_r)) <<< 1);
    gnum = (35'(gwz_r) + 35'(gxy_r)) <<< 1;
    gden = 35'sd268435456 - ((35'(gyy_r) + 35'(gzz_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vs0_r.yaw  <= vec_prep(den, num);
      vs0_r.gyaw <= vec_prep(gden, gnum);
      vs0_r.brg  <= vec_prep(35'(dx_r), 35'(dy_r));
      vs0_r.rx   <= rot_scale(dx_r);
      vs0_r.ry   <= rot_scale(dy_r);
    end
  end

  ggvc_pkg::vstage_t vc [S+1];
  ggvc_pkg::rstage_t rc [S+1];

  assign vc[0] = vs0_r;

  for (genvar i = 0; i < S; i++) begin : g_vec
    ggvc_vec_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .en  (en[2+i]),
      .d_i (vc[i]),
      .d_o (vc[i+1])
    );
  end

  logic [15:0]          yaw16, gyaw16, brg16;
  logic [31:0]          ang_a;
  ggvc_pkg::rstage_t    rs_nxt, rs0_r;

  always_comb begin
    yaw16  = ang16(vc[S].yaw);
    gyaw16 = ang16(vc[S].gyaw);
    brg16  = ang16(vc[S].brg);
    ang_a  = 32'h0 - {yaw16, 16'h0};
    rs_nxt.x = vc[S].rx;
    rs_nxt.y = vc[S].ry;
    if (ang_a >= 32'h4000_0000 && ang_a < 32'hC000_0000) begin
      rs_nxt.x = -vc[S].rx;
      rs_nxt.y = -vc[S].ry;
      ang_a    = ang_a + 32'h8000_0000;
    end
    rs_nxt.z  = 33'($signed(ang_a));
    rs_nxt.ep = $signed(brg16 - yaw16);
    rs_nxt.eh = $signed(gyaw16 - yaw16);
  end

  always_ff @(posedge clk) begin
    if (en[2+S]) begin
      rs0_r <= rs_nxt;
    end
  end

  assign rc[0] = rs0_r;

  for (genvar i = 0; i < S; i++) begin : g_rot
    ggvc_rot_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .en  (en[3+S+i]),
      .d_i (rc[i]),
      .d_o (rc[i+1])
    );
  end

  logic signed [RW-1:0]  xr, yr;
  logic signed [EXW-1:0] ex_c;
  logic signed [16:0]    ep17;

  always_comb begin
    xr   = (rc[S].x + RW'(32768)) >>> 16;
    yr   = (rc[S].y + RW'(32768)) >>> 16;
    ex_c = xr[EXW-1:0];
    ep17 = 17'(rc[S].ep);
  end

  logic signed [EXW-1:0] ex1_r, ey1_r, ex2_r, ex3_r;
  logic        [16:0]    aep1_r;
  logic                  sel1_r;
  logic signed [15:0]    ep1_r, eh1_r;
  logic        [33:0]    gprod2_r;
  logic signed [50:0]    sprod2_r, sprod3_r, sprod4_r;
  logic signed [36:0]    tprod2_r, tprod3_r, tprod4_r;
  logic signed [18:0]    gain3_r;
  logic signed [55:0]    fprod4_r;
  logic        [33:0]    gdrop;
  ggvc_pkg::out_t        out_r;

  assign gdrop = (gprod2_r + 34'd8192) >> 14;

  always_ff @(posedge clk) begin
    if (en[3+2*S]) begin
      ex1_r  <= ex_c;
      ey1_r  <= yr[EXW-1:0];
      aep1_r <= (ep17 < 0) ? 17'(-ep17) : 17'(ep17);
      sel1_r <= ex_c >= ggvc_pkg::SWITCH_Q16;
      ep1_r  <= rc[S].ep;
      eh1_r  <= rc[S].eh;
    end
    if (en[4+2*S]) begin
      gprod2_r <= 34'(aep1_r) * ggvc_pkg::FWD_DROP_Q16;
      sprod2_r <= 51'(ey1_r) * ggvc_pkg::STRAFE_GAIN_Q16;
      tprod2_r <= sel1_r ? 37'(ep1_r) * ggvc_pkg::PATH_TURN_Q16
                         : 37'(eh1_r) * ggvc_pkg::HEAD_TURN_Q16;
      ex2_r    <= ex1_r;
    end
    if (en[5+2*S]) begin
      gain3_r  <= ggvc_pkg::FWD_GAIN_Q16 - $signed(gdrop[18:0]);
      ex3_r    <= ex2_r;
      sprod3_r <= sprod2_r;
      tprod3_r <= tprod2_r;
    end
    if (en[6+2*S]) begin
      fprod4_r <= 56'(gain3_r) * 56'(ex3_r);
      sprod4_r <= sprod3_r;
      tprod4_r <= tprod3_r;
    end
    if (en[7+2*S]) begin
      out_r.forward_speed <= ggvc_pkg::rnd_sat(64'(fprod4_r));
      out_r.strafe_speed  <= ggvc_pkg::rnd_sat(64'(sprod4_r));
      out_r.turn_rate     <= ggvc_pkg::rnd_sat(64'(tprod4_r));
    end
  end

  assign out_ch.valid = v_r[L-1];
  assign out_ch.data  = out_r;

endmodule
